@@ rtl/core/psc_pkg.sv @@
// Shared types and constants for the pressure sensor compensation core.
// Used by psc_datapath and pressure_sensor_compensation_core; no dependencies.
`default_nettype none

package psc_pkg;

  // Field widths
  localparam int unsigned TEMP_W      = 16;
  localparam int unsigned PRES_W      = 16;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned OUT_W       = 20;
  localparam int unsigned S_TDATA_W   = 40;
  localparam int unsigned M_TDATA_W   = 24;

  // Configuration port
  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_CALIB_LOADED   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_SENS_BASE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_SENS_LIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_SENS_QUAD = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_OFF_BASE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_OFF_LIN   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_COEF_OFF_QUAD  = 3'd6;

  // Only readings with this payload length are compensated
  localparam logic [LEN_W-1:0] PAYLOAD_LEN = 8'd4;

  // Pipeline depth: input, products, quadratic terms, sums, sens*P, output
  localparam int unsigned NUM_STAGES = 6;

  typedef struct packed {
    logic        [COEF_W-1:0] sens_base;  // c3, unsigned
    logic        [COEF_W-1:0] sens_lin;   // c4, unsigned
    logic signed [COEF_W-1:0] sens_quad;  // c5
    logic signed [COEF_W-1:0] off_base;   // c6
    logic signed [COEF_W-1:0] off_lin;    // c7
    logic signed [COEF_W-1:0] off_quad;   // c8
  } psc_coef_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;  // per-stage register enable
  } psc_stage_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/psc_datapath.sv @@
// Six-stage compensation datapath (payload registers only, no valid tracking).
// Depends on psc_pkg; stage enables come from the top-level valid/ready chain.
`default_nettype none

module psc_datapath (
  input  wire logic                                 clk_i,
  input  wire psc_pkg::psc_stage_ctrl_t             ctrl_i,
  input  wire psc_pkg::psc_coef_t                   coef_i,
  input  wire logic signed [psc_pkg::TEMP_W-1:0]    raw_temp_i,
  input  wire logic        [psc_pkg::PRES_W-1:0]    raw_pressure_i,
  output      logic signed [psc_pkg::OUT_W-1:0]     pressure_pa_o
);

  // stage 1: captured reading
  logic signed [15:0] t1_q;
  logic        [15:0] p1_q;

  // stage 2: T*T and linear terms
  logic signed [31:0] tt_full;
  logic signed [32:0] sens_lin_prod;
  logic signed [31:0] off_lin_prod;
  logic        [30:0] tt2_q;
  logic signed [15:0] sens_lin2_q;
  logic signed [28:0] off_lin2_q;
  logic        [15:0] p2_q;

  // stage 3: quadratic terms
  logic signed [47:0] sens_quad_prod;
  logic signed [47:0] off_quad_prod;
  logic signed [13:0] sens_quad3_q;
  logic signed [28:0] off_quad3_q;
  logic signed [15:0] sens_lin3_q;
  logic signed [28:0] off_lin3_q;
  logic        [15:0] p3_q;

  // stage 4: sensitivity and offset
  logic signed [19:0] sens_d;
  logic signed [31:0] offs_d;
  logic signed [19:0] sens4_q;
  logic signed [31:0] offs4_q;
  logic        [15:0] p4_q;

  // stage 5: sens*P
  logic signed [36:0] sp_prod;
  logic signed [36:0] sp5_q;
  logic signed [31:0] offs5_q;

  // stage 6: final sum and shift
  logic signed [37:0] total;
  logic signed [19:0] res6_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      t1_q <= raw_temp_i;
      p1_q <= raw_pressure_i;
    end
  end

  assign tt_full       = t1_q * t1_q;
  assign sens_lin_prod = $signed({1'b0, coef_i.sens_lin}) * t1_q;
  assign off_lin_prod  = coef_i.off_lin * t1_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      tt2_q       <= tt_full[30:0];         // T*T <= 2^30, never negative
      sens_lin2_q <= sens_lin_prod[32:17];  // floor(c4*T / 2^17)
      off_lin2_q  <= off_lin_prod[31:3];    // floor(c7*T / 2^3)
      p2_q        <= p1_q;
    end
  end

  assign sens_quad_prod = coef_i.sens_quad * $signed({17'b0, tt2_q});
  assign off_quad_prod  = coef_i.off_quad * $signed({17'b0, tt2_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      sens_quad3_q <= sens_quad_prod[47:34];  // floor(c5*T*T / 2^34)
      off_quad3_q  <= off_quad_prod[47:19];   // floor(c8*T*T / 2^19)
      sens_lin3_q  <= sens_lin2_q;
      off_lin3_q   <= off_lin2_q;
      p3_q         <= p2_q;
    end
  end

  assign sens_d = $signed({4'b0, coef_i.sens_base})
                + {{4{sens_lin3_q[15]}}, sens_lin3_q}
                + {{6{sens_quad3_q[13]}}, sens_quad3_q};

  assign offs_d = {{2{coef_i.off_base[15]}}, coef_i.off_base, 14'b0}
                + {{3{off_lin3_q[28]}}, off_lin3_q}
                + {{3{off_quad3_q[28]}}, off_quad3_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      sens4_q <= sens_d;
      offs4_q <= offs_d;
      p4_q    <= p3_q;
    end
  end

  assign sp_prod = sens4_q * $signed({1'b0, p4_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[4]) begin
      sp5_q   <= sp_prod;
      offs5_q <= offs4_q;
    end
  end

  assign total = {sp5_q[36], sp5_q} + {{6{offs5_q[31]}}, offs5_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[5]) begin
      res6_q <= total[33:14];  // floor(total / 2^14), low 20 bits
    end
  end

  assign pressure_pa_o = res6_q;

endmodule

`default_nettype wire

@@ rtl/core/pressure_sensor_compensation_core.sv @@
// Top level of the pressure sensor compensation core: APB register file,
// stream handshake and valid/ready chain. Depends on psc_pkg and psc_datapath.
//
// Usage
//   Slave stream (s_axis_*): one raw reading per transfer. tdata carries
//   raw_temp [15:0] (signed), raw_pressure [31:16], payload_bytes [39:32].
//   Readings whose payload_bytes is not 4, or that arrive while calib_loaded
//   is 0, are consumed and produce nothing.
//   Master stream (m_axis_*): compensated pressure in pascals, signed 20 bits
//   in tdata [19:0], upper bits zero. Divide by 100 for hPa downstream.
//   APB: registers at byte offsets 0x00 calib_loaded, 0x04 c3, 0x08 c4,
//   0x0C c5, 0x10 c6, 0x14 c7, 0x18 c8. No wait states; write only while idle.
// Timing
//   Six register stages. Throughput is one reading per cycle while
//   m_axis_tready is high, set by the fully pipelined multipliers (T*T,
//   linear terms, quadratic terms, sens*P).
// Reset and backpressure
//   rst_ni clears all stage valid bits and the configuration registers to 0;
//   the datapath registers are not reset and hold don't-care data.
//   When m_axis_tready is low the output holds and stages fill up one by one
//   (bubbles are squeezed out); s_axis_tready drops only when all are full.
`default_nettype none

module pressure_sensor_compensation_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  // reading stream
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // [15:0] raw_temp, [31:16] raw_pressure, [39:32] payload_bytes
  input  wire logic [psc_pkg::S_TDATA_W-1:0]    s_axis_tdata,

  // result stream
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [19:0] pressure_pa, [23:20] zero
  output      logic [psc_pkg::M_TDATA_W-1:0]    m_axis_tdata,

  // APB configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [psc_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [psc_pkg::APB_DATA_W-1:0]   pwdata,
  output      logic [psc_pkg::APB_DATA_W-1:0]   prdata,
  output      logic                             pready
);

  localparam int unsigned NS = psc_pkg::NUM_STAGES;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                             calib_loaded_q;
  psc_pkg::psc_coef_t               coef_q;
  logic [psc_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[psc_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_loaded_q <= 1'b0;
      coef_q         <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        psc_pkg::REG_CALIB_LOADED:   calib_loaded_q     <= pwdata[0];
        psc_pkg::REG_COEF_SENS_BASE: coef_q.sens_base   <= pwdata[15:0];
        psc_pkg::REG_COEF_SENS_LIN:  coef_q.sens_lin    <= pwdata[15:0];
        psc_pkg::REG_COEF_SENS_QUAD: coef_q.sens_quad   <= pwdata[15:0];
        psc_pkg::REG_COEF_OFF_BASE:  coef_q.off_base    <= pwdata[15:0];
        psc_pkg::REG_COEF_OFF_LIN:   coef_q.off_lin     <= pwdata[15:0];
        psc_pkg::REG_COEF_OFF_QUAD:  coef_q.off_quad    <= pwdata[15:0];
        default: ;  // unmapped offset, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      psc_pkg::REG_CALIB_LOADED:   prdata = {31'b0, calib_loaded_q};
      psc_pkg::REG_COEF_SENS_BASE: prdata = {16'b0, coef_q.sens_base};
      psc_pkg::REG_COEF_SENS_LIN:  prdata = {16'b0, coef_q.sens_lin};
      psc_pkg::REG_COEF_SENS_QUAD: prdata = {16'b0, coef_q.sens_quad};
      psc_pkg::REG_COEF_OFF_BASE:  prdata = {16'b0, coef_q.off_base};
      psc_pkg::REG_COEF_OFF_LIN:   prdata = {16'b0, coef_q.off_lin};
      psc_pkg::REG_COEF_OFF_QUAD:  prdata = {16'b0, coef_q.off_quad};
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Valid/ready chain: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic [NS-1:0]             vld_q;
  logic [NS-1:0]             stg_rdy;
  logic                      in_keep;
  psc_pkg::psc_stage_ctrl_t  ctrl;

  always_comb begin
    stg_rdy[NS-1] = ~vld_q[NS-1] | m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      stg_rdy[k] = ~vld_q[k] | stg_rdy[k+1];
    end
  end

  // Readings with the wrong length or before calibration are swallowed here
  assign in_keep = s_axis_tvalid & calib_loaded_q
                 & (s_axis_tdata[39:32] == psc_pkg::PAYLOAD_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_rdy[0]) begin
        vld_q[0] <= in_keep;
      end
      for (int k = 1; k < NS; k++) begin
        if (stg_rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign ctrl.load     = stg_rdy;
  assign s_axis_tready = stg_rdy[0];
  assign m_axis_tvalid = vld_q[NS-1];

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic signed [psc_pkg::OUT_W-1:0] pressure_pa;

  psc_datapath u_datapath (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .coef_i         (coef_q),
    .raw_temp_i     (s_axis_tdata[15:0]),
    .raw_pressure_i (s_axis_tdata[31:16]),
    .pressure_pa_o  (pressure_pa)
  );

  assign m_axis_tdata = {4'b0, pressure_pa};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A filtered reading never occupies the first stage.
  a_filter_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     (!calib_loaded_q || s_axis_tdata[39:32] != psc_pkg::PAYLOAD_LEN))
    |=> !vld_q[0])
    else $error("filtered reading entered pipeline");

  // Full pipeline with a stalled sink must refuse new readings.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline full and stalled");

  // An item in the last inner stage moves to the output when it may.
  a_last_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-2] && stg_rdy[NS-1]) |=> vld_q[NS-1])
    else $error("item lost before output stage");

endmodule

`default_nettype wire
